### design/chm_pkg.sv
// Package for the convex hull merge block: payload structs, states, constants.
// Used by convex_hull_merge and its checker; depends on nothing.
`default_nettype none
package chm_pkg;
    localparam int MaxVerts = 32;
    localparam int CoordW   = 12;
    localparam int IdxW     = 5;

    typedef struct packed {
        logic              hull_select;
        logic [CoordW-1:0] x_coord;
        logic [CoordW-1:0] y_coord;
        logic              start_merge;
    } t_in;

    typedef struct packed {
        logic [CoordW-1:0] out_x;
        logic [CoordW-1:0] out_y;
        logic [IdxW-1:0]   upper_a;
        logic [IdxW-1:0]   upper_b;
        logic [IdxW-1:0]   lower_a;
        logic [IdxW-1:0]   lower_b;
        logic              is_last;
    } t_out;

    // Sequencer states. Memory reads are registered, so reads are issued
    // in one state and the data is used in the next.
    typedef enum logic [4:0] {
        S_LOAD,
        S_EXT_RD,    // issue extreme scan read
        S_EXT_CHK,   // compare scanned vertex
        S_TAN_RD,    // read A[ia], B[ib]
        S_TAN_RD2,   // read neighbor vertex
        S_TAN_CHK,   // evaluate orientation
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT_OUT
    } t_state;
endpackage
`default_nettype wire

### design/convex_hull_merge.sv
// Convex hull merge top level: vertex stores, tangent walk sequencer, output.
// Depends on chm_pkg.
//
// Vertices are taken one per cycle while loading, unless the last result of a
// ring is still waiting to be taken. On the request that carries start_merge the
// block scans both stores for the extreme vertices, walks the upper and lower
// tangents (one shared cross product unit fed from the two vertex memories),
// and then emits the merged ring vertex by vertex.
// No request is taken from the start of the merge until its last result has
// been taken.
`default_nettype none
module convex_hull_merge #(
    parameter int MAX_VERTS = chm_pkg::MaxVerts
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire chm_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output chm_pkg::t_out      o_data
);
    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int LW = CW + 1;
    localparam int CD = chm_pkg::CoordW;

    // Vertex memories, x in the upper half.
    logic [2*CD-1:0] mem_a [MAX_VERTS];
    logic [2*CD-1:0] mem_b [MAX_VERTS];
    logic [2*CD-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]   rd_addr_a, rd_addr_b;

    chm_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [AW-1:0] r_ia, r_ib, n_ia, n_ib, r_ra, r_lb, n_ra, n_lb;
    logic [AW-1:0] r_ua, r_ub, n_ua, n_ub, r_la, r_lbb, n_la, n_lbb;
    logic [CW-1:0] r_scan, n_scan, r_k, n_k;
    logic [LW-1:0] r_rounds, n_rounds;
    logic          r_lower, n_lower;   // 0: upper tangent, 1: lower
    logic          r_phase, n_phase;   // 0: first walk of a round (A for upper, B for lower)
    logic          r_done, n_done;
    logic          r_emit_b, n_emit_b;
    logic [AW-1:0] r_ei, n_ei;
    logic [CD-1:0] r_ext_a, r_ext_b, n_ext_a, n_ext_b;
    logic [2*CD-1:0] r_p1, r_q1, n_p1, n_q1;
    logic          r_ovalid, n_ovalid;
    chm_pkg::t_out r_odata, n_odata;

    logic [AW-1:0] cnt_a_m1, cnt_b_m1;
    assign cnt_a_m1 = AW'(r_cnt_a - 1'b1);
    assign cnt_b_m1 = AW'(r_cnt_b - 1'b1);

    function automatic logic [AW-1:0] f_nxt(input logic [AW-1:0] i, input logic [AW-1:0] m);
        f_nxt = (i == m) ? '0 : AW'(i + 1'b1);
    endfunction
    function automatic logic [AW-1:0] f_prv(input logic [AW-1:0] i, input logic [AW-1:0] m);
        f_prv = (i == '0) ? m : AW'(i - 1'b1);
    endfunction

    // Memory writes during load and registered reads.
    logic wr_ok_a, wr_ok_b, acc;
    assign acc     = i_valid && o_ready;
    assign wr_ok_a = acc && !i_data.hull_select && (r_cnt_a < CW'(MAX_VERTS));
    assign wr_ok_b = acc &&  i_data.hull_select && (r_cnt_b < CW'(MAX_VERTS));
    always_ff @(posedge i_clk) begin
        if (wr_ok_a) mem_a[r_cnt_a[AW-1:0]] <= {i_data.x_coord, i_data.y_coord};
        if (wr_ok_b) mem_b[r_cnt_b[AW-1:0]] <= {i_data.x_coord, i_data.y_coord};
        r_rd_a <= mem_a[rd_addr_a];
        r_rd_b <= mem_b[rd_addr_b];
    end

    // Walk order per round. Upper: phase 0 moves A forward on a positive sign,
    // phase 1 moves B backward on a negative sign. Lower: phase 0 moves B
    // forward, phase 1 moves A backward. The walked hull is A when the tangent
    // select equals the phase.
    logic on_a;     // current step walks hull A
    assign on_a = (r_lower == r_phase);

    // Shared orientation unit: sign of (q2-q1) x (q1-p1), q2 from memory.
    logic [2*CD-1:0] q2;
    logic signed [CD:0] dx1, dy1, dx2, dy2;
    logic signed [2*CD+2:0] prod_a, prod_b, cr;
    assign q2     = on_a ? r_rd_a : r_rd_b;
    assign dx1    = $signed({1'b0, q2[2*CD-1:CD]})   - $signed({1'b0, r_q1[2*CD-1:CD]});
    assign dy1    = $signed({1'b0, q2[CD-1:0]})      - $signed({1'b0, r_q1[CD-1:0]});
    assign dx2    = $signed({1'b0, r_q1[2*CD-1:CD]}) - $signed({1'b0, r_p1[2*CD-1:CD]});
    assign dy2    = $signed({1'b0, r_q1[CD-1:0]})    - $signed({1'b0, r_p1[CD-1:0]});
    assign prod_a = dx1 * dy2;
    assign prod_b = dy1 * dx2;
    assign cr     = prod_a - prod_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= chm_pkg::S_LOAD;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_ovalid <= n_ovalid;
        end
        r_ia <= n_ia; r_ib <= n_ib; r_ra <= n_ra; r_lb <= n_lb;
        r_ua <= n_ua; r_ub <= n_ub; r_la <= n_la; r_lbb <= n_lbb;
        r_scan <= n_scan; r_k <= n_k; r_rounds <= n_rounds;
        r_lower <= n_lower; r_phase <= n_phase; r_done <= n_done;
        r_emit_b <= n_emit_b; r_ei <= n_ei;
        r_ext_a <= n_ext_a; r_ext_b <= n_ext_b; r_p1 <= n_p1; r_q1 <= n_q1;
        r_odata <= n_odata;
    end

    logic [CW-1:0] kmax;
    logic move;
    logic [LW-1:0] limit;
    assign limit = LW'(r_cnt_a) + LW'(r_cnt_b) + 1'b1;

    // Sequencer.
    always_comb begin
        n_state = r_state; n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b;
        n_ia = r_ia; n_ib = r_ib; n_ra = r_ra; n_lb = r_lb;
        n_ua = r_ua; n_ub = r_ub; n_la = r_la; n_lbb = r_lbb;
        n_scan = r_scan; n_k = r_k; n_rounds = r_rounds;
        n_lower = r_lower; n_phase = r_phase; n_done = r_done;
        n_emit_b = r_emit_b; n_ei = r_ei;
        n_ext_a = r_ext_a; n_ext_b = r_ext_b; n_p1 = r_p1; n_q1 = r_q1;
        n_ovalid = r_ovalid && !i_ready;
        n_odata = r_odata;
        rd_addr_a = r_ia; rd_addr_b = r_ib;
        o_ready = 1'b0;
        kmax = on_a ? r_cnt_a : r_cnt_b;
        move = 1'b0;
        unique case (r_state)
            chm_pkg::S_LOAD: begin
                // The last result of a ring must be gone before loading resumes.
                o_ready = !r_ovalid;
                if (acc) begin
                    if (wr_ok_a) n_cnt_a = CW'(r_cnt_a + 1'b1);
                    if (wr_ok_b) n_cnt_b = CW'(r_cnt_b + 1'b1);
                    if (i_data.start_merge) begin
                        if (n_cnt_a == '0 || n_cnt_b == '0) begin
                            n_cnt_a = '0; n_cnt_b = '0;
                        end else begin
                            n_state = chm_pkg::S_EXT_RD;
                            n_scan = '0; n_ra = '0; n_lb = '0;
                        end
                    end
                end
            end
            chm_pkg::S_EXT_RD: begin
                rd_addr_a = r_scan[AW-1:0]; rd_addr_b = r_scan[AW-1:0];
                n_state = chm_pkg::S_EXT_CHK;
            end
            chm_pkg::S_EXT_CHK: begin
                if (r_scan < r_cnt_a && (r_scan == '0 ||
                        r_rd_a[2*CD-1:CD] > r_ext_a)) begin
                    n_ra = r_scan[AW-1:0]; n_ext_a = r_rd_a[2*CD-1:CD];
                end
                if (r_scan < r_cnt_b && (r_scan == '0 ||
                        r_rd_b[2*CD-1:CD] < r_ext_b)) begin
                    n_lb = r_scan[AW-1:0]; n_ext_b = r_rd_b[2*CD-1:CD];
                end
                n_scan = CW'(r_scan + 1'b1);
                if (n_scan >= r_cnt_a && n_scan >= r_cnt_b) begin
                    n_state = chm_pkg::S_TAN_RD;
                    n_ia = n_ra; n_ib = n_lb; n_lower = 1'b0; n_phase = 1'b0;
                    n_rounds = '0; n_done = 1'b1; n_k = '0;
                end else begin
                    n_state = chm_pkg::S_EXT_RD;
                end
            end
            chm_pkg::S_TAN_RD: begin
                // Read p1 and q1: current points.
                n_state = chm_pkg::S_TAN_RD2;
                if (r_k == '0 && !r_phase) begin
                    n_rounds = LW'(r_rounds + 1'b1);
                    n_done = 1'b1;
                end
            end
            chm_pkg::S_TAN_RD2: begin
                n_p1 = on_a ? r_rd_b : r_rd_a;
                n_q1 = on_a ? r_rd_a : r_rd_b;
                // Neighbor: forward in phase 0, backward in phase 1.
                if (on_a) rd_addr_a = r_phase ? f_prv(r_ia, cnt_a_m1) : f_nxt(r_ia, cnt_a_m1);
                else      rd_addr_b = r_phase ? f_prv(r_ib, cnt_b_m1) : f_nxt(r_ib, cnt_b_m1);
                n_state = chm_pkg::S_TAN_CHK;
            end
            chm_pkg::S_TAN_CHK: begin
                move = (r_k < kmax) && (r_phase ? (cr < 0) : (cr > 0));
                n_state = chm_pkg::S_TAN_RD;
                if (move) begin
                    if (on_a) n_ia = r_phase ? f_prv(r_ia, cnt_a_m1) : f_nxt(r_ia, cnt_a_m1);
                    else      n_ib = r_phase ? f_prv(r_ib, cnt_b_m1) : f_nxt(r_ib, cnt_b_m1);
                    if (r_phase) n_done = 1'b0;
                    n_k = CW'(r_k + 1'b1);
                end else begin
                    n_k = '0;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (r_done || r_rounds >= limit) begin
                            if (!r_lower) begin
                                n_ua = r_ia; n_ub = r_ib; n_lower = 1'b1;
                                n_ia = r_ra; n_ib = r_lb; n_rounds = '0;
                            end else begin
                                n_la = r_ia; n_lbb = r_ib;
                                n_state = chm_pkg::S_EMIT_RD;
                                n_ei = r_ua; n_emit_b = 1'b0;
                            end
                        end
                    end
                end
            end
            chm_pkg::S_EMIT_RD: begin
                rd_addr_a = r_ei; rd_addr_b = r_ei;
                n_state = chm_pkg::S_EMIT_WAIT;
            end
            chm_pkg::S_EMIT_WAIT: begin
                // Keep the read address so the vertex stays put while stalled.
                rd_addr_a = r_ei; rd_addr_b = r_ei;
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata.out_x = r_emit_b ? r_rd_b[2*CD-1:CD] : r_rd_a[2*CD-1:CD];
                    n_odata.out_y = r_emit_b ? r_rd_b[CD-1:0] : r_rd_a[CD-1:0];
                    n_odata.upper_a = chm_pkg::IdxW'(r_ua);
                    n_odata.upper_b = chm_pkg::IdxW'(r_ub);
                    n_odata.lower_a = chm_pkg::IdxW'(r_la);
                    n_odata.lower_b = chm_pkg::IdxW'(r_lbb);
                    n_odata.is_last = r_emit_b && (r_ei == r_ub);
                    n_state = chm_pkg::S_EMIT_OUT;
                end
            end
            chm_pkg::S_EMIT_OUT: begin
                n_state = chm_pkg::S_EMIT_RD;
                if (!r_emit_b) begin
                    if (r_ei == r_la) begin
                        n_emit_b = 1'b1; n_ei = r_lbb;
                    end else begin
                        n_ei = f_nxt(r_ei, cnt_a_m1);
                    end
                end else if (r_ei == r_ub) begin
                    n_state = chm_pkg::S_LOAD;
                    n_cnt_a = '0; n_cnt_b = '0;
                end else begin
                    n_ei = f_nxt(r_ei, cnt_b_m1);
                end
            end
            default: n_state = chm_pkg::S_LOAD;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule
`default_nettype wire

### design/chm_checker.sv
// Port-level checker for convex_hull_merge, bound to the top level.
// Depends on chm_pkg.
`default_nettype none
module chm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          o_ready,
    input wire chm_pkg::t_in  i_data,
    input wire logic          o_valid,
    input wire logic          i_ready,
    input wire chm_pkg::t_out o_data
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    // Requests are refused while results are pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken during emit");
    // A loading request never produces a result right away.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_data.start_merge |=> !o_valid)
        else $error("result after loading request");
    // Once the last result is taken the block is ready again.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.is_last |=> o_ready)
        else $error("not ready after ring end");
endmodule
bind convex_hull_merge chm_checker u_chm_checker (.*);
`default_nettype wire

### sim/chm_checker.sv
// Checker for convex_hull_merge: watches the request and result channels, predicts the merged ring
// and compares every result field. Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_monitor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire chm_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire chm_pkg::t_out i_out_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_merges
);
    logic [23:0]   ring_a [chm_pkg::MaxVerts];
    logic [23:0]   ring_b [chm_pkg::MaxVerts];
    int            held_a;
    int            held_b;
    chm_pkg::t_out ring_q [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_merges  = 0;
        held_a    = 0;
        held_b    = 0;
    end

    // Sign of (q2-q1) x (q1-p1).
    function automatic int turn_sign(logic [23:0] p1, logic [23:0] q1, logic [23:0] q2);
        longint dx1, dy1, dx2, dy2, c;
        dx1 = longint'(q2[23:12]) - longint'(q1[23:12]);
        dy1 = longint'(q2[11:0]) - longint'(q1[11:0]);
        dx2 = longint'(q1[23:12]) - longint'(p1[23:12]);
        dy2 = longint'(q1[11:0]) - longint'(p1[11:0]);
        c = dx1 * dy2 - dy1 * dx2;
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    function automatic int fwd(int i, int n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function automatic int back(int i, int n);
        return (i == 0) ? n - 1 : i - 1;
    endfunction

    // Find both tangents and queue the merged ring.
    task automatic merge_rings(int na, int nb);
        int            ra, lb, ia, ib, rounds, k, i, ua, ub, la, lbb, limit, first;
        bit            done;
        chm_pkg::t_out r;
        ra = 0;
        for (i = 1; i < na; i++) if (ring_a[i][23:12] > ring_a[ra][23:12]) ra = i;
        lb = 0;
        for (i = 1; i < nb; i++) if (ring_b[i][23:12] < ring_b[lb][23:12]) lb = i;
        limit = na + nb + 1;

        // Upper tangent.
        ia = ra; ib = lb; done = 0; rounds = 0;
        while (!done && rounds < limit) begin
            done = 1;
            rounds++;
            for (k = 0; k < na && turn_sign(ring_b[ib], ring_a[ia], ring_a[fwd(ia, na)]) > 0;
                 k++) ia = fwd(ia, na);
            for (k = 0; k < nb && turn_sign(ring_a[ia], ring_b[ib], ring_b[back(ib, nb)]) < 0;
                 k++) begin
                ib = back(ib, nb);
                done = 0;
            end
        end
        ua = ia; ub = ib;

        // Lower tangent.
        ia = ra; ib = lb; done = 0; rounds = 0;
        while (!done && rounds < limit) begin
            done = 1;
            rounds++;
            for (k = 0; k < nb && turn_sign(ring_a[ia], ring_b[ib], ring_b[fwd(ib, nb)]) > 0;
                 k++) ib = fwd(ib, nb);
            for (k = 0; k < na && turn_sign(ring_b[ib], ring_a[ia], ring_a[back(ia, na)]) < 0;
                 k++) begin
                ia = back(ia, na);
                done = 0;
            end
        end
        la = ia; lbb = ib;

        // Ring order: A from upper to lower, then B from lower to upper.
        first = ring_q.size();
        r.upper_a = chm_pkg::IdxW'(ua);
        r.upper_b = chm_pkg::IdxW'(ub);
        r.lower_a = chm_pkg::IdxW'(la);
        r.lower_b = chm_pkg::IdxW'(lbb);
        r.is_last = 1'b0;
        i = ua;
        forever begin
            r.out_x = ring_a[i][23:12];
            r.out_y = ring_a[i][11:0];
            ring_q = {ring_q, r};
            if (i == la) break;
            i = fwd(i, na);
        end
        i = lbb;
        forever begin
            r.out_x = ring_b[i][23:12];
            r.out_y = ring_b[i][11:0];
            ring_q = {ring_q, r};
            if (i == ub) break;
            i = fwd(i, nb);
        end
        if (ring_q.size() > first) ring_q[ring_q.size() - 1].is_last = 1'b1;
    endtask

    // Track accepted vertices and compare accepted results.
    always @(posedge i_clk) begin
        chm_pkg::t_out want;
        int            na, nb;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                if (!i_in_data.hull_select) begin
                    if (held_a < chm_pkg::MaxVerts) begin
                        ring_a[held_a] = {i_in_data.x_coord, i_in_data.y_coord};
                        held_a++;
                    end
                end else if (held_b < chm_pkg::MaxVerts) begin
                    ring_b[held_b] = {i_in_data.x_coord, i_in_data.y_coord};
                    held_b++;
                end
                if (i_in_data.start_merge) begin
                    na = held_a;
                    nb = held_b;
                    held_a = 0;
                    held_b = 0;
                    o_merges++;
                    if (na != 0 && nb != 0) merge_rings(na, nb);
                end
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (ring_q.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", i_out_data.out_x, i_out_data.out_y);
                    o_errors++;
                end else begin
                    want = ring_q.pop_front();
                    if (i_out_data.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, i_out_data.out_x);
                        o_errors++;
                    end
                    if (i_out_data.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, i_out_data.out_y);
                        o_errors++;
                    end
                    if (i_out_data.upper_a !== want.upper_a) begin
                        $error("upper_a: expected %0d, got %0d", want.upper_a,
                               i_out_data.upper_a);
                        o_errors++;
                    end
                    if (i_out_data.upper_b !== want.upper_b) begin
                        $error("upper_b: expected %0d, got %0d", want.upper_b,
                               i_out_data.upper_b);
                        o_errors++;
                    end
                    if (i_out_data.lower_a !== want.lower_a) begin
                        $error("lower_a: expected %0d, got %0d", want.lower_a,
                               i_out_data.lower_a);
                        o_errors++;
                    end
                    if (i_out_data.lower_b !== want.lower_b) begin
                        $error("lower_b: expected %0d, got %0d", want.lower_b,
                               i_out_data.lower_b);
                        o_errors++;
                    end
                    if (i_out_data.is_last !== want.is_last) begin
                        $error("is_last: expected %0d, got %0d", want.is_last,
                               i_out_data.is_last);
                        o_errors++;
                    end
                end
            end
            o_pending = ring_q.size();
        end
    end
endmodule

### sim/testbench.sv
// Top of the convex_hull_merge bench: clock, reset, vertex stimulus and the verdict.
// Depends on chm_pkg, convex_hull_merge and chm_monitor.
`timescale 1ns / 1ps
module testbench;
    localparam real TwoPi = 6.283185307179586;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    chm_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready;
    chm_pkg::t_out out_data;
    int            errors, pending, results, merges;
    int            sent;
    bit            steady;

    convex_hull_merge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    chm_monitor u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_merges    (merges)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none during a steady stretch.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stalls at random.
    initial begin
        int stall;
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall = pick_gap();
            if (stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end
        end
    end

    // Send one vertex request and wait until it is accepted.
    task automatic send_vertex(bit sel, int x, int y, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{hull_select: sel, x_coord: chm_pkg::CoordW'(x),
                      y_coord: chm_pkg::CoordW'(y), start_merge: last};
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    // Load a roughly regular polygon around (cx, cy), either winding.
    task automatic send_ring(bit sel, int n, int cx, int cy, int rad, bit ccw, bit last);
        real a0, ang;
        int  k, x, y;
        a0 = TwoPi * $urandom_range(0, 999) / 1000.0;
        for (k = 0; k < n; k++) begin
            ang = a0 + (ccw ? 1.0 : -1.0) * TwoPi * k / n;
            x = cx + int'(rad * $cos(ang));
            y = cy + int'(rad * $sin(ang));
            x = (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
            y = (y < 0) ? 0 : ((y > 4095) ? 4095 : y);
            send_vertex(sel, x, y, last && (k == n - 1));
        end
    endtask

    function automatic int ring_size();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(3, 10);
    endfunction

    initial begin
        int  k, n, pick;
        bit  ccw;
        sent = 0;
        steady = 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        i_rst_n  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        // Triangles touching the coordinate extremes.
        send_vertex(1'b0, 0, 0, 1'b0);
        send_vertex(1'b0, 100, 2000, 1'b0);
        send_vertex(1'b0, 0, 4095, 1'b0);
        send_vertex(1'b1, 4095, 4095, 1'b0);
        send_vertex(1'b1, 3900, 2000, 1'b0);
        send_vertex(1'b1, 4095, 0, 1'b1);
        // Empty hull B, then empty hull A.
        send_vertex(1'b0, 10, 20, 1'b0);
        send_vertex(1'b0, 30, 40, 1'b1);
        send_vertex(1'b1, 2000, 2000, 1'b1);
        // One vertex in each hull.
        send_vertex(1'b0, 2048, 2048, 1'b0);
        send_vertex(1'b1, 2050, 2048, 1'b1);
        // Ties on the extreme x in both hulls.
        send_vertex(1'b0, 1000, 1000, 1'b0);
        send_vertex(1'b0, 1000, 3000, 1'b0);
        send_vertex(1'b0, 500, 2000, 1'b0);
        send_vertex(1'b0, 1000, 2000, 1'b0);
        send_vertex(1'b1, 3000, 1000, 1'b0);
        send_vertex(1'b1, 3000, 3000, 1'b0);
        send_vertex(1'b1, 3500, 2000, 1'b1);
        // Collinear points on one line across both hulls.
        send_vertex(1'b0, 100, 100, 1'b0);
        send_vertex(1'b0, 200, 200, 1'b0);
        send_vertex(1'b1, 300, 300, 1'b0);
        send_vertex(1'b1, 400, 400, 1'b1);

        // Random part: mostly well-formed hull pairs, some noise.
        while (sent < 220) begin
            steady = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            ccw = $urandom_range(0, 1);
            if (pick < 8) begin
                send_ring(1'b0, ring_size(), $urandom_range(500, 1700),
                          $urandom_range(800, 3300), $urandom_range(100, 500), ccw, 1'b0);
                send_ring(1'b1, ring_size(), $urandom_range(2400, 3600),
                          $urandom_range(800, 3300), $urandom_range(100, 500), ccw, 1'b1);
            end else begin
                n = $urandom_range(1, 7);
                for (k = 0; k < n; k++)
                    send_vertex($urandom_range(0, 1), $urandom_range(0, 4095),
                                $urandom_range(0, 4095), k == n - 1);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d vertex requests, %0d merges and %0d ring results.",
                 sent, merges, results);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #100000000;
        $display("Timed out with %0d results still expected.", pending);
        $display("Regression FAIL");
        $finish;
    end
endmodule

### sim.f
design/chm_pkg.sv
design/convex_hull_merge.sv
design/chm_checker.sv
sim/chm_checker.sv
sim/testbench.sv
